@@ design/pts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Types, codes and sizing constants shared by the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int COUNT_BITS = 16;
    localparam int MAX_OUT    = 8;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);

    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_ADD      = 2'd1;
    localparam logic [1:0] ACT_DELETE   = 2'd2;
    localparam logic [1:0] ACT_DISPATCH = 2'd3;

    localparam logic [2:0] ST_TICKED    = 3'd0;
    localparam logic [2:0] ST_ADDED     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;
    localparam logic [2:0] ST_RUN_TASK  = 3'd5;
    localparam logic [2:0] ST_NONE      = 3'd6;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  task_tag;
        logic [15:0] first_delay;
        logic [15:0] run_period;
        logic [2:0]  slot_index;
    } pts_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] result_slot;
        logic [7:0] result_tag;
        logic       last;
    } pts_out_t;

    function automatic logic [2:0] to_slot3(input logic [SLOT_W-1:0] s);
        logic [31:0] t;
        t = 32'(s);
        return t[2:0];
    endfunction

    function automatic count_t to_count(input logic [15:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[COUNT_BITS-1:0];
    endfunction

endpackage

@@ design/periodic_task_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit
// Time-triggered cooperative scheduler: a table of task slots walked one
// slot per cycle, save where a dispatch walk pauses, by a sequencer sharing a single decrement unit.
// ----------------------------------------------------------------------------
//  channel  | ports                      | payload
//  ---------+----------------------------+-------------------------------
//  input    | s_valid, s_ready, s_data   | action, tag, delay, period, index
//  result   | m_valid, m_ready, m_data   | status, slot, tag, last
//
//  a transaction is accepted, then walks the table one slot at a time, then
//  posts the final result
//  dispatch walk pauses on a ready slot while a run result is already held and the result register is full
//  the final result waits while the result register is full
//  aresetn is synchronous, active low; it empties the table
// ----------------------------------------------------------------------------
module periodic_task_scheduler_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pts_pkg::pts_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pts_pkg::pts_out_t m_data
);
    import pts_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    logic [1:0]           state_reg, state_next;
    pts_in_t              cur_reg, cur_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic [2:0]           found_slot_reg, found_slot_next;
    logic                 hold_valid_reg, hold_valid_next;
    pts_out_t             hold_reg, hold_next;
    logic                 out_valid_reg, out_valid_next;
    pts_out_t             out_reg, out_next;

    logic [NUM_SLOTS-1:0] slot_valid_reg;
    logic [7:0]           slot_tag_reg     [NUM_SLOTS];
    count_t               slot_delay_reg   [NUM_SLOTS];
    count_t               slot_period_reg  [NUM_SLOTS];
    logic [7:0]           slot_pending_reg [NUM_SLOTS];

    logic                 slot_we;
    logic                 valid_next;
    logic [7:0]           tag_next;
    count_t               delay_next;
    count_t               period_next;
    logic [7:0]           pending_next;

    logic                 cv;
    logic [7:0]           ctag;
    count_t               cdelay;
    count_t               cperiod;
    logic [7:0]           cpend;
    count_t               dec_in;
    count_t               dec_out;
    logic                 out_free;
    logic                 advance;
    logic                 bad_index;
    pts_out_t             final_res;

    assign cv      = slot_valid_reg[idx_reg];
    assign ctag    = slot_tag_reg[idx_reg];
    assign cdelay  = slot_delay_reg[idx_reg];
    assign cperiod = slot_period_reg[idx_reg];
    assign cpend   = slot_pending_reg[idx_reg];

    // shared decrement unit
    assign dec_in  = (cdelay == '0) ? cperiod : cdelay;
    assign dec_out = dec_in - count_t'(1);

    assign out_free  = !out_valid_reg || m_ready;
    assign bad_index = 32'(cur_reg.slot_index) >= NUM_SLOTS;

    always_comb begin
        final_res = '0;
        final_res.last = 1'b1;
        unique case (cur_reg.action)
            ACT_TICK: begin
                final_res.status = ST_TICKED;
            end
            ACT_ADD: begin
                final_res.status      = found_reg ? ST_ADDED : ST_FULL;
                final_res.result_slot = found_reg ? found_slot_reg : 3'd0;
            end
            ACT_DELETE: begin
                final_res.status      = bad_index ? ST_BAD_INDEX : ST_DELETED;
                final_res.result_slot = bad_index ? 3'd0 : cur_reg.slot_index;
            end
            ACT_DISPATCH: begin
                if (hold_valid_reg) begin
                    final_res = hold_reg;
                    final_res.last = 1'b1;
                end else begin
                    final_res.status = ST_NONE;
                end
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        slot_we         = 1'b0;
        valid_next      = cv;
        tag_next        = ctag;
        delay_next      = cdelay;
        period_next     = cperiod;
        pending_next    = cpend;
        advance         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cur_next        = s_data;
                    idx_next        = '0;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    hold_valid_next = 1'b0;
                    state_next      = S_WALK;
                end
            end
            S_WALK: begin
                advance = 1'b1;
                unique case (cur_reg.action)
                    ACT_TICK: begin
                        if (cv) begin
                            slot_we = 1'b1;
                            if (cdelay == '0) begin
                                if (cpend != 8'hFF) begin
                                    pending_next = cpend + 8'd1;
                                end
                                if (cperiod != '0) begin
                                    delay_next = dec_out;
                                end
                            end else begin
                                delay_next = dec_out;
                            end
                        end
                    end
                    ACT_ADD: begin
                        if (!cv && !found_reg) begin
                            slot_we         = 1'b1;
                            valid_next      = 1'b1;
                            tag_next        = cur_reg.task_tag;
                            delay_next      = to_count(cur_reg.first_delay);
                            period_next     = to_count(cur_reg.run_period);
                            pending_next    = 8'd0;
                            found_next      = 1'b1;
                            found_slot_next = to_slot3(idx_reg);
                        end
                    end
                    ACT_DELETE: begin
                        if (32'(cur_reg.slot_index) == 32'(idx_reg)) begin
                            slot_we      = 1'b1;
                            valid_next   = 1'b0;
                            pending_next = 8'd0;
                        end
                    end
                    ACT_DISPATCH: begin
                        if (cv && cpend != 8'd0 && 32'(cnt_reg) < MAX_OUT) begin
                            if (hold_valid_reg && !out_free) begin
                                advance = 1'b0;
                            end else begin
                                if (hold_valid_reg) begin
                                    out_valid_next = 1'b1;
                                    out_next       = hold_reg;
                                end
                                hold_valid_next       = 1'b1;
                                hold_next.status      = ST_RUN_TASK;
                                hold_next.result_slot = to_slot3(idx_reg);
                                hold_next.result_tag  = ctag;
                                hold_next.last        = 1'b0;
                                cnt_next              = cnt_reg + CNT_W'(1);
                                slot_we               = 1'b1;
                                pending_next          = cpend - 8'd1;
                                if (cperiod == '0) begin
                                    valid_next = 1'b0;
                                end
                            end
                        end
                    end
                endcase
                if (advance) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next        = final_res;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end else begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (slot_we) begin
                slot_valid_reg[idx_reg] <= valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        found_slot_reg <= found_slot_next;
        hold_reg       <= hold_next;
        out_reg        <= out_next;
        if (slot_we) begin
            slot_tag_reg[idx_reg]     <= tag_next;
            slot_delay_reg[idx_reg]   <= delay_next;
            slot_period_reg[idx_reg]  <= period_next;
            slot_pending_reg[idx_reg] <= pending_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held result left over in idle");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after accept");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (32'(cnt_reg) <= MAX_OUT))
        else $error("dispatch count overran");

    a_flush_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && out_free) |=> (m_valid && s_ready))
        else $error("final result not posted");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for periodic_task_scheduler_unit. A queue-fed driver
// offers tick, add, delete and dispatch transactions with random gaps, and a
// scoreboard built from an in-bench copy of the task table predicts every
// result. The monitor checks each result, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import pts_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES  = 4 * (NUM_SLOTS + 2);

    typedef struct {
        pts_in_t data;
        bit      drain;
    } stim_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pts_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pts_out_t m_data;

    periodic_task_scheduler_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // task table copy
    logic       tbl_valid   [NUM_SLOTS];
    logic [7:0] tbl_tag     [NUM_SLOTS];
    count_t     tbl_delay   [NUM_SLOTS];
    count_t     tbl_period  [NUM_SLOTS];
    logic [7:0] tbl_pending [NUM_SLOTS];

    stim_t    item_q   [$];
    pts_out_t answer_q [$];

    int cycle_cnt = 0;
    int err_cnt   = 0;
    int n_items   = 0;
    int n_results = 0;
    int n_runs    = 0;
    int n_full    = 0;

    function automatic pts_in_t mk_item(logic [1:0] act, logic [7:0] tag,
                                        logic [15:0] dly, logic [15:0] per,
                                        logic [2:0] idx);
        pts_in_t it;
        it.action      = act;
        it.task_tag    = tag;
        it.first_delay = dly;
        it.run_period  = per;
        it.slot_index  = idx;
        return it;
    endfunction

    function automatic pts_out_t mk_answer(logic [2:0] st, logic [2:0] slot,
                                           logic [7:0] tag, logic lst);
        pts_out_t r;
        r.status      = st;
        r.result_slot = slot;
        r.result_tag  = tag;
        r.last        = lst;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_item(pts_in_t it, bit drain);
        stim_t e;
        e.data  = it;
        e.drain = drain;
        item_q.push_back(e);
    endtask

    task automatic clear_entry(int s);
        tbl_valid[s]   = 1'b0;
        tbl_tag[s]     = '0;
        tbl_delay[s]   = '0;
        tbl_period[s]  = '0;
        tbl_pending[s] = '0;
    endtask

    // update the table for one transaction and queue the results it causes
    task automatic sched_action(pts_in_t it);
        int s;
        int n;
        bit placed;
        case (it.action)
            ACT_TICK: begin
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (tbl_valid[s]) begin
                        if (tbl_delay[s] == '0) begin
                            if (tbl_pending[s] != 8'hFF) tbl_pending[s] = tbl_pending[s] + 8'd1;
                            if (tbl_period[s] != '0) tbl_delay[s] = tbl_period[s] - 1'b1;
                        end else begin
                            tbl_delay[s] = tbl_delay[s] - 1'b1;
                        end
                    end
                end
                answer_q.push_back(mk_answer(ST_TICKED, 3'd0, 8'd0, 1'b1));
            end
            ACT_ADD: begin
                placed = 1'b0;
                for (s = 0; s < NUM_SLOTS && !placed; s++) begin
                    if (!tbl_valid[s]) begin
                        tbl_valid[s]   = 1'b1;
                        tbl_tag[s]     = it.task_tag;
                        tbl_delay[s]   = it.first_delay;
                        tbl_period[s]  = it.run_period;
                        tbl_pending[s] = '0;
                        answer_q.push_back(mk_answer(ST_ADDED, s[2:0], 8'd0, 1'b1));
                        placed = 1'b1;
                    end
                end
                if (!placed) begin
                    answer_q.push_back(mk_answer(ST_FULL, 3'd0, 8'd0, 1'b1));
                    n_full++;
                end
            end
            ACT_DELETE: begin
                if (int'(it.slot_index) >= NUM_SLOTS) begin
                    answer_q.push_back(mk_answer(ST_BAD_INDEX, 3'd0, 8'd0, 1'b1));
                end else begin
                    clear_entry(int'(it.slot_index));
                    answer_q.push_back(mk_answer(ST_DELETED, it.slot_index, 8'd0, 1'b1));
                end
            end
            default: begin
                n = 0;
                for (s = 0; s < NUM_SLOTS && n < MAX_OUT; s++) begin
                    if (tbl_valid[s] && tbl_pending[s] != 8'd0) begin
                        answer_q.push_back(mk_answer(ST_RUN_TASK, s[2:0], tbl_tag[s], 1'b0));
                        n++;
                        n_runs++;
                        tbl_pending[s] = tbl_pending[s] - 8'd1;
                        if (tbl_period[s] == '0) clear_entry(s);
                    end
                end
                if (n == 0) begin
                    answer_q.push_back(mk_answer(ST_NONE, 3'd0, 8'd0, 1'b1));
                end else begin
                    answer_q[answer_q.size() - 1].last = 1'b1;
                end
            end
        endcase
    endtask

    // driver
    int    gap_in  = 0;
    int    calm_in = 0;
    stim_t next_in;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                sched_action(s_data);
                n_items++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_in > 0) begin
                    gap_in--;
                    s_valid <= 1'b0;
                end else if (item_q.size() > 0 &&
                             (!item_q[0].drain || answer_q.size() == 0)) begin
                    next_in = item_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= next_in.data;
                    if (calm_in > 0) begin
                        calm_in--;
                        gap_in = 0;
                    end else begin
                        gap_in = idle_len();
                        if ($urandom_range(0, 49) == 0) calm_in = 40;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result ready generation, with one long hold-off
    int stall_out = 0;
    int calm_out  = 0;
    int hold_out  = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!hold_done && n_items >= 150) begin
                hold_out  = 400;
                hold_done = 1'b1;
            end
            if (hold_out > 0) begin
                hold_out--;
                m_ready <= 1'b0;
            end else if (calm_out > 0) begin
                calm_out--;
                m_ready <= 1'b1;
            end else if (stall_out > 0) begin
                stall_out--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_out = idle_len();
                if ($urandom_range(0, 59) == 0) calm_out = 80;
            end
        end
    end

    // monitor
    pts_out_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (answer_q.size() == 0) begin
                $error("unexpected result transaction: status %0d slot %0d tag %0d last %0d",
                       m_data.status, m_data.result_slot, m_data.result_tag, m_data.last);
                err_cnt++;
            end else begin
                want = answer_q.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    err_cnt++;
                end
                if (m_data.result_slot !== want.result_slot) begin
                    $error("result_slot: expected %0d, got %0d",
                           want.result_slot, m_data.result_slot);
                    err_cnt++;
                end
                if (m_data.result_tag !== want.result_tag) begin
                    $error("result_tag: expected %0d, got %0d",
                           want.result_tag, m_data.result_tag);
                    err_cnt++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        int i;
        int r;
        int total_items;
        logic [1:0]  act;
        logic [15:0] dly;
        logic [15:0] per;

        for (i = 0; i < NUM_SLOTS; i++) clear_entry(i);

        // directed: empty table, fill to full, extremes, multi-run dispatch
        push_item(mk_item(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_TICK,     8'hFF, 16'hFFFF, 16'hFFFF, 3'd7), 1'b0);
        push_item(mk_item(ACT_DELETE,   8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_DELETE,   8'hFF, 16'hFFFF, 16'hFFFF, 3'd7), 1'b0);
        push_item(mk_item(ACT_ADD,      8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_ADD,      8'hFF, 16'hFFFF, 16'hFFFF, 3'd7), 1'b0);
        push_item(mk_item(ACT_ADD,      8'hA5, 16'h0000, 16'h0001, 3'd2), 1'b0);
        push_item(mk_item(ACT_ADD,      8'h5A, 16'h0001, 16'h0002, 3'd5), 1'b0);
        push_item(mk_item(ACT_ADD,      8'h3C, 16'h0002, 16'h0000, 3'd1), 1'b0);
        push_item(mk_item(ACT_ADD,      8'hC3, 16'h0000, 16'h8000, 3'd6), 1'b0);
        push_item(mk_item(ACT_ADD,      8'h01, 16'h0000, 16'h0003, 3'd3), 1'b0);
        push_item(mk_item(ACT_ADD,      8'h80, 16'h0000, 16'h0000, 3'd4), 1'b0);
        push_item(mk_item(ACT_ADD,      8'h7F, 16'h5555, 16'hAAAA, 3'd0), 1'b0);
        push_item(mk_item(ACT_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_DELETE,   8'h00, 16'h0000, 16'h0000, 3'd1), 1'b0);
        push_item(mk_item(ACT_DELETE,   8'h00, 16'h0000, 16'h0000, 3'd7), 1'b0);
        push_item(mk_item(ACT_ADD,      8'h42, 16'hFFFF, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        push_item(mk_item(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);

        // random: mostly small delays and periods so tasks fire often
        for (i = 0; i < 180; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) act = ACT_TICK;
            else if (r < 62) act = ACT_ADD;
            else if (r < 74) act = ACT_DELETE;
            else act = ACT_DISPATCH;
            dly = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, 5));
            r = $urandom_range(0, 9);
            if (r == 0) per = 16'($urandom_range(0, 65535));
            else if (r < 4) per = 16'd0;
            else per = 16'($urandom_range(1, 6));
            push_item(mk_item(act, 8'($urandom_range(0, 255)), dly, per,
                              3'($urandom_range(0, 7))), (i % 60) == 0);
        end

        // pending count saturation: one every-tick task, no dispatch for 258 ticks
        for (i = 0; i < NUM_SLOTS; i++) begin
            push_item(mk_item(ACT_DELETE, 8'h00, 16'h0000, 16'h0000, 3'(i)), i == 0);
        end
        push_item(mk_item(ACT_ADD, 8'h96, 16'h0000, 16'h0001, 3'd0), 1'b0);
        for (i = 0; i < 258; i++) begin
            push_item(mk_item(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        end
        for (i = 0; i < 4; i++) begin
            push_item(mk_item(ACT_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0), 1'b0);
        end

        total_items = item_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while ((n_items < total_items || answer_q.size() != 0) &&
               cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
        end

        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, answer_q.size());
            $display("Regression FAIL");
        end else begin
            repeat (TAIL_CYCLES) @(posedge aclk);
            if (answer_q.size() != 0) begin
                $error("%0d expected results never arrived", answer_q.size());
                err_cnt++;
            end
            $display("covered %0d transactions in, %0d results out (%0d task runs, %0d full)",
                     n_items, n_results, n_runs, n_full);
            $display("incl. empty/full table, one-shot removal and pending saturation; %0d errors",
                     err_cnt);
            if (err_cnt == 0) begin
                $display("Regression PASS");
            end else begin
                $display("Regression FAIL");
            end
        end
        $finish;
    end

endmodule

@@ periodic_task_scheduler_unit.f @@
design/pts_pkg.sv
design/periodic_task_scheduler_unit.sv
tb/tb.sv
